// ===== rtl/ita_pkg.sv =====
// ita_pkg: shared types and constants of the integer to ascii converter
// request payload structs, controller/datapath command and status groups
// no dependencies
`default_nettype none
package ita_pkg;

  localparam int BUFFER_SIZE = 34;
  localparam int MAX_TEXT    = 33;
  localparam int CAP_INT     = (BUFFER_SIZE - 1 < MAX_TEXT) ? BUFFER_SIZE - 1 : MAX_TEXT;
  localparam logic [5:0] WIDTH_CAP = 6'(CAP_INT);

  localparam logic [5:0] RADIX_MIN  = 6'd2;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam logic [7:0] LETTER_GAP = 8'd7;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // reciprocal scale: quotient estimate is (value * floor(2^RECIP_SHIFT / radix)) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W      = 32 + RECIP_SHIFT;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  radix;
    logic        signed_mode;
    logic [5:0]  min_width;
    logic        zero_pad;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic [5:0] length;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic fix;
    logic emit;
  } ita_cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic emit_last;
    logic out_free;
  } ita_sts_t;

endpackage
`default_nettype wire

// ===== rtl/ita_dp.sv =====
// ita_dp: datapath of the converter, reciprocal divider, digit store, text emitter
// and the result output register; driven by commands from ita_ctrl
// depends on ita_pkg
`default_nettype none
module ita_dp import ita_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_t      in_data,
  input  wire ita_cmd_t cmd,
  output ita_sts_t      sts,
  input  wire logic     out_ready,
  output logic          out_valid,
  output out_t          out_data
);

  localparam logic [PROD_W-1:0] RECIP_ONE = PROD_W'(1) << RECIP_SHIFT;

  logic [RECIP_SHIFT-1:0] recip_tab [0:36];

  for (genvar g = 0; g <= 36; g++) begin : g_recip
    localparam logic [RECIP_SHIFT-1:0] M = RECIP_SHIFT'(RECIP_ONE / ((g < 2) ? 1 : g));
    assign recip_tab[g] = M;
  end

  logic [31:0]       v_r;
  logic [5:0]        radix_r;
  logic              neg_r;
  logic [5:0]        width_r;
  logic [7:0]        pad_r;
  logic [5:0]        nd_r;
  logic [PROD_W-1:0] prod_r;
  logic [5:0]        pos_r;
  logic [7:0]        digits_r [0:31];
  logic              out_valid_r;
  out_t              out_r;

  logic [5:0]  radix_sat;
  logic        neg_in;
  logic [5:0]  width_sat;
  logic [31:0] q_est;
  logic [7:0]  prod_lo;
  logic [7:0]  rem;
  logic        rem_ge;
  logic [7:0]  digit;
  logic [31:0] q_fix;
  logic [7:0]  asc;
  logic [5:0]  total;
  logic [5:0]  len;
  logic [5:0]  padn;
  logic [4:0]  dig_idx;
  logic        is_last;
  out_t        out_nxt;

  always_comb begin
    if (in_data.radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (in_data.radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = in_data.radix;
    end
    neg_in    = in_data.signed_mode & in_data.value[31];
    width_sat = (in_data.min_width > WIDTH_CAP) ? WIDTH_CAP : in_data.min_width;
  end

  // one digit: estimate quotient, then a single compare and subtract
  always_comb begin
    q_est   = prod_r[PROD_W-1:RECIP_SHIFT];
    prod_lo = q_est[7:0] * {2'b00, radix_r};
    rem     = v_r[7:0] - prod_lo;
    rem_ge  = rem >= {2'b00, radix_r};
    digit   = rem_ge ? rem - {2'b00, radix_r} : rem;
    q_fix   = q_est + {31'd0, rem_ge};
    asc     = (digit < 8'd10) ? CHAR_ZERO + digit : CHAR_ZERO + digit + LETTER_GAP;
  end

  // text layout: padding, sign, digits most significant first
  always_comb begin
    total   = nd_r + {5'd0, neg_r};
    len     = (total > width_r) ? total : width_r;
    padn    = len - total;
    dig_idx = 5'(len - 6'd1 - pos_r);
    is_last = pos_r == len - 6'd1;
    if (pos_r < padn) begin
      out_nxt.character = pad_r;
    end else if (neg_r && pos_r == padn) begin
      out_nxt.character = CHAR_MINUS;
    end else begin
      out_nxt.character = digits_r[dig_idx];
    end
    out_nxt.last   = is_last;
    out_nxt.length = is_last ? len : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r     <= neg_in ? 32'd0 - in_data.value : in_data.value;
      radix_r <= radix_sat;
      neg_r   <= neg_in;
      width_r <= width_sat;
      pad_r   <= in_data.zero_pad ? CHAR_ZERO : CHAR_SPACE;
      nd_r    <= 6'd0;
      pos_r   <= 6'd0;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(v_r) * PROD_W'(recip_tab[radix_r]);
    end
    if (cmd.fix) begin
      digits_r[nd_r[4:0]] <= asc;
      nd_r                <= nd_r + 6'd1;
      v_r                 <= q_fix;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
      pos_r <= pos_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.quot_zero = q_fix == 32'd0;
  assign sts.emit_last = is_last;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule
`default_nettype wire

// ===== rtl/ita_ctrl.sv =====
// ita_ctrl: sequencing state machine of the converter
// issues load, divide and emit commands to ita_dp; depends on ita_pkg
`default_nettype none
module ita_ctrl import ita_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire ita_sts_t sts,
  output ita_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = sts.quot_zero ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/int_to_ascii_radix_padded.sv =====
// int_to_ascii_radix_padded: top level of the integer to ascii converter
// joins the controller ita_ctrl and the datapath ita_dp; depends on ita_pkg
//
//   channel  ports                          payload
//   input    in_valid / in_ready / in_data    in_t  (value, radix, mode, width, pad)
//   result   out_valid / out_ready / out_data out_t (character, last, length)
//
// one request takes a load step, then for each digit a multiply by the reciprocal
// and a correct-and-store step, then one emit step per character, each of which
// waits while the output register is still full.
// a new request is taken only once the last character is in the output register.
// reset clears the state machine and the output valid; a stalled output holds its character.
`default_nettype none
module int_to_ascii_radix_padded import ita_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  ita_cmd_t cmd;
  ita_sts_t sts;

  ita_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ita_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== bench/tb_int_to_ascii_radix_padded.sv =====
// tb_int_to_ascii_radix_padded: self-checking bench for the integer to ascii converter
// drives random and directed conversion requests, predicts every character in a scoreboard
// depends on ita_pkg and int_to_ascii_radix_padded
module tb_int_to_ascii_radix_padded import ita_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 150;
  localparam int QUIET_LIMIT = 3000;
  localparam int REPORT_LIMIT = 10;

  class ascii_scoreboard;
    out_t expected_chars[$];
    int   errors;
    int   n_requests;
    int   n_chars;

    function new();
      errors = 0;
      n_requests = 0;
      n_chars = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // padding, then sign, then digits most significant first
    function void render_text(in_t req);
      logic [31:0] mag;
      logic [31:0] rem;
      logic [5:0]  base;
      logic [5:0]  wid;
      logic [7:0]  pad_ch;
      logic [7:0]  digit;
      logic [7:0]  digit_ch [32];
      logic [7:0]  text [$];
      out_t        item;
      bit          neg;
      int          nd;
      int          k;
      base = req.radix;
      if (base < RADIX_MIN) base = RADIX_MIN;
      if (base > RADIX_MAX) base = RADIX_MAX;
      wid = (req.min_width > WIDTH_CAP) ? WIDTH_CAP : req.min_width;
      pad_ch = req.zero_pad ? CHAR_ZERO : CHAR_SPACE;
      neg = req.signed_mode && req.value[31];
      mag = neg ? 32'(0) - req.value : req.value;
      nd = 0;
      do begin
        rem = mag % {26'd0, base};
        digit = rem[7:0];
        if (rem >= 10) digit = digit + LETTER_GAP;
        digit_ch[nd] = digit + CHAR_ZERO;
        nd++;
        mag = mag / {26'd0, base};
      end while (mag != 0);
      k = nd + (neg ? 1 : 0);
      while (k < int'(wid) && text.size() < MAX_TEXT) begin
        text.push_back(pad_ch);
        k++;
      end
      if (neg && text.size() < MAX_TEXT) text.push_back(CHAR_MINUS);
      while (nd > 0 && text.size() < MAX_TEXT) begin
        nd--;
        text.push_back(digit_ch[nd]);
      end
      foreach (text[i]) begin
        item.character = text[i];
        item.last = (i == text.size() - 1);
        item.length = item.last ? 6'(text.size()) : 6'd0;
        expected_chars.push_back(item);
      end
    endfunction

    function void note_request(in_t req);
      n_requests++;
      render_text(req);
    endfunction

    function void check_char(out_t got);
      out_t want;
      n_chars++;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected character %02h last %0b length %0d with nothing pending",
                   got.character, got.last, got.length);
        return;
      end
      want = expected_chars.pop_front();
      if (got.character !== want.character || got.last !== want.last ||
          got.length !== want.length) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch at character %0d: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                   n_chars, want.character, want.last, want.length,
                   got.character, got.last, got.length);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  ascii_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  int_to_ascii_radix_padded dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_data);
    if (rst_n && out_valid && out_ready) sb.check_char(out_data);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request or character moved for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // receiver with random stalls and a single long hold-off
  initial begin : receiver
    int n;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic in_t make_req(logic [31:0] value, logic [5:0] radix, logic sgn,
                                   logic [5:0] width, logic pad);
    in_t r;
    r.value = value;
    r.radix = radix;
    r.signed_mode = sgn;
    r.min_width = width;
    r.zero_pad = pad;
    return r;
  endfunction

  function automatic in_t random_request();
    in_t r;
    case ($urandom_range(0, 9))
      0, 1, 2: r.value = $urandom();
      3, 4:    r.value = $urandom_range(0, 99);
      5:       r.value = 32'(0) - 32'($urandom_range(1, 99));
      6: begin
        case ($urandom_range(0, 3))
          0: r.value = 32'h0000_0000;
          1: r.value = 32'hFFFF_FFFF;
          2: r.value = 32'h8000_0000;
          default: r.value = 32'h7FFF_FFFF;
        endcase
      end
      default: r.value = $urandom() >> $urandom_range(0, 31);
    endcase
    r.radix = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(2, 36));
    r.signed_mode = 1'($urandom_range(0, 1));
    r.min_width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 12));
    r.zero_pad = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_request(input in_t req);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 46;
    send_request(make_req(32'd0, 6'd10, 1'b0, 6'd0, 1'b0));
    send_request(make_req(32'hFFFF_FFFF, 6'd2, 1'b0, 6'd0, 1'b0));
    send_request(make_req(32'h8000_0000, 6'd2, 1'b1, 6'd63, 1'b1));
    send_request(make_req(32'h8000_0000, 6'd10, 1'b1, 6'd0, 1'b0));
    send_request(make_req(32'hFFFF_FFFF, 6'd10, 1'b1, 6'd0, 1'b0));
    send_request(make_req(32'hFFFF_FFFF, 6'd10, 1'b0, 6'd0, 1'b0));
    send_request(make_req(32'h7FFF_FFFF, 6'd36, 1'b1, 6'd0, 1'b0));
    send_request(make_req(32'd5, 6'd0, 1'b0, 6'd0, 1'b0));
    send_request(make_req(32'd5, 6'd1, 1'b0, 6'd0, 1'b0));
    send_request(make_req(32'd12345, 6'd37, 1'b0, 6'd0, 1'b0));
    send_request(make_req(32'hFFFF_FFFF, 6'd63, 1'b0, 6'd0, 1'b0));
    send_request(make_req(32'hFFFF_FFFB, 6'd10, 1'b1, 6'd4, 1'b0));
    send_request(make_req(32'hFFFF_FFFB, 6'd10, 1'b1, 6'd4, 1'b1));
    send_request(make_req(32'd123456, 6'd10, 1'b0, 6'd3, 1'b1));
    send_request(make_req(32'd7, 6'd8, 1'b0, 6'd33, 1'b1));
    send_request(make_req(32'd7, 6'd8, 1'b0, 6'd34, 1'b0));
    send_request(make_req(32'hDEAD_BEEF, 6'd16, 1'b0, 6'd8, 1'b1));
    send_request(make_req(32'd35, 6'd36, 1'b0, 6'd0, 1'b0));
    send_request(make_req(32'd10, 6'd11, 1'b0, 6'd1, 1'b0));
    send_request(make_req(32'd42, 6'd10, 1'b1, 6'd5, 1'b1));
    send_request(make_req(32'd0, 6'd2, 1'b1, 6'd63, 1'b0));
    send_request(make_req(32'h0000_0001, 6'd3, 1'b1, 6'd2, 1'b1));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (phase == 0 && i == 40) hold_off = 1'b1;
        if (i == 80) drain_requests();
        send_request(random_request());
      end
    end

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d conversions and %0d characters checked, radix 0..63 and widths 0..63,",
             sb.n_requests, sb.n_chars);
    $display("signed and unsigned, both pad choices, with stalls on both sides");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d characters never arrived", sb.errors, sb.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule
